[sv/gptr_pkg.sv]
// ----------------------------------------------------------------------------
// gptr_pkg
// Shared types, widths and helpers for the gaze to pan/tilt rotation block.
// ----------------------------------------------------------------------------
package gptr_pkg;

  localparam int QW = 15;   // result magnitude bits, 0..16384
  localparam int RW = 98;   // residual width, holds (2q-1)^2 * d
  localparam int DW = 64;   // denominator width
  localparam int NL = 8;    // root lanes
  localparam int NSH = 30;  // 4 * 16384^2 = 2^30

  localparam logic [QW-1:0] QONE = 15'd16384;

  localparam int L_M00 = 0;
  localparam int L_M10 = 1;
  localparam int L_M20 = 2;
  localparam int L_M22 = 3;
  localparam int L_M01 = 4;
  localparam int L_M11 = 5;
  localparam int L_M02 = 6;
  localparam int L_M12 = 7;

  typedef struct packed {
    logic signed [15:0] gaze_x;
    logic signed [15:0] gaze_y;
    logic signed [15:0] gaze_z;
  } gaze_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rot_t;

  // residual r = n - (2q-1)^2 * d, ud = (2q-1) * d
  typedef struct packed {
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] ud;
    logic [DW-1:0]        d;
    logic [QW-1:0]        q;
  } lane_t;

  typedef struct packed {
    logic [NL-1:0] neg;
    logic          zero_all;
    logic          vert;
    logic          z_pos;
  } side_t;

  function automatic lane_t root_init(logic [RW-1:0] n, logic [DW-1:0] d);
    lane_t o;
    logic signed [RW-1:0] dx;
    dx = $signed(RW'(d));
    o.r = $signed(n) - dx;
    o.ud = -dx;
    o.d = d;
    o.q = '0;
    return o;
  endfunction

  // try setting bit k of q
  function automatic lane_t root_step(lane_t l, int unsigned k);
    lane_t o;
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] cand;
    logic signed [RW-1:0] rn;
    o = l;
    dx = $signed(RW'(l.d));
    cand = (l.ud <<< (k + 2)) + (dx <<< (2 * k + 2));
    rn = l.r - cand;
    if (!rn[RW-1]) begin
      o.r = rn;
      o.ud = l.ud + (dx <<< (k + 1));
      o.q = l.q | (QW'(1) << k);
    end
    return o;
  endfunction

endpackage

[sv/gptr_prep.sv]
// ----------------------------------------------------------------------------
// gptr_prep
// Magnitudes, squares and cross products; seeds the eight root lanes.
// ----------------------------------------------------------------------------
module gptr_prep (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  gptr_pkg::gaze_t              gaze,
  output logic                         vld,
  output gptr_pkg::lane_t              lanes [gptr_pkg::NL],
  output gptr_pkg::side_t              side
);

  logic        a_vld, b_vld, c_vld, d_vld;
  logic [15:0] a_ax, a_ay, a_az;
  gptr_pkg::side_t a_side, b_side, c_side, d_side;
  logic [31:0] b_sx, b_sy, b_sz;
  logic [31:0] c_sx, c_sy, c_sz;
  logic [32:0] c_rr;
  logic [33:0] c_ss;
  logic [63:0] c_xz, c_yz;
  logic [31:0] d_sx, d_sy, d_sz;
  logic [32:0] d_rr;
  logic [33:0] d_ss;
  logic [63:0] d_xz, d_yz, d_rs;

  logic xn, xp, yn, yp, zn, zp;
  gptr_pkg::side_t a_side_next;

  always_comb begin
    xn = gaze.gaze_x[15];
    yn = gaze.gaze_y[15];
    zn = gaze.gaze_z[15];
    xp = !xn && (gaze.gaze_x != 16'sd0);
    yp = !yn && (gaze.gaze_y != 16'sd0);
    zp = !zn && (gaze.gaze_z != 16'sd0);
    a_side_next = '0;
    a_side_next.neg[gptr_pkg::L_M00] = xn;
    a_side_next.neg[gptr_pkg::L_M10] = yn;
    a_side_next.neg[gptr_pkg::L_M20] = zn;
    a_side_next.neg[gptr_pkg::L_M22] = 1'b0;
    a_side_next.neg[gptr_pkg::L_M01] = yp;
    a_side_next.neg[gptr_pkg::L_M11] = xn;
    a_side_next.neg[gptr_pkg::L_M02] = (xp && zp) || (xn && zn);
    a_side_next.neg[gptr_pkg::L_M12] = (yp && zp) || (yn && zn);
    a_side_next.z_pos = zp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      vld   <= 1'b0;
    end else begin
      a_vld <= start;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      vld   <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ax   <= xn ? 16'(-gaze.gaze_x) : 16'(gaze.gaze_x);
    a_ay   <= yn ? 16'(-gaze.gaze_y) : 16'(gaze.gaze_y);
    a_az   <= zn ? 16'(-gaze.gaze_z) : 16'(gaze.gaze_z);
    a_side <= a_side_next;

    b_sx   <= 32'(a_ax) * 32'(a_ax);
    b_sy   <= 32'(a_ay) * 32'(a_ay);
    b_sz   <= 32'(a_az) * 32'(a_az);
    b_side <= a_side;

    c_sx <= b_sx;
    c_sy <= b_sy;
    c_sz <= b_sz;
    c_rr <= 33'(b_sx) + 33'(b_sy);
    c_ss <= 34'(b_sx) + 34'(b_sy) + 34'(b_sz);
    c_xz <= 64'(b_sx) * 64'(b_sz);
    c_yz <= 64'(b_sy) * 64'(b_sz);
    c_side <= b_side;

    d_sx <= c_sx;
    d_sy <= c_sy;
    d_sz <= c_sz;
    d_rr <= c_rr;
    d_ss <= c_ss;
    d_xz <= c_xz;
    d_yz <= c_yz;
    d_rs <= 64'(c_rr) * 64'(c_ss);
    d_side <= '{neg: c_side.neg, zero_all: (c_ss == 34'd0), vert: (c_rr == 33'd0),
                z_pos: c_side.z_pos};

    side <= d_side;
    lanes[gptr_pkg::L_M00] <= gptr_pkg::root_init(gptr_pkg::RW'(d_sx) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_ss));
    lanes[gptr_pkg::L_M10] <= gptr_pkg::root_init(gptr_pkg::RW'(d_sy) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_ss));
    lanes[gptr_pkg::L_M20] <= gptr_pkg::root_init(gptr_pkg::RW'(d_sz) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_ss));
    lanes[gptr_pkg::L_M22] <= gptr_pkg::root_init(gptr_pkg::RW'(d_rr) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_ss));
    lanes[gptr_pkg::L_M01] <= gptr_pkg::root_init(gptr_pkg::RW'(d_sy) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_rr));
    lanes[gptr_pkg::L_M11] <= gptr_pkg::root_init(gptr_pkg::RW'(d_sx) << gptr_pkg::NSH,
                                                  gptr_pkg::DW'(d_rr));
    lanes[gptr_pkg::L_M02] <= gptr_pkg::root_init(gptr_pkg::RW'(d_xz) << gptr_pkg::NSH,
                                                  d_rs);
    lanes[gptr_pkg::L_M12] <= gptr_pkg::root_init(gptr_pkg::RW'(d_yz) << gptr_pkg::NSH,
                                                  d_rs);
  end

endmodule

[sv/gptr_search.sv]
// ----------------------------------------------------------------------------
// gptr_search
// Pipelined bit-by-bit rounded root search, one result bit per stage.
// ----------------------------------------------------------------------------
module gptr_search (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  gptr_pkg::lane_t in_lanes [gptr_pkg::NL],
  input  gptr_pkg::side_t in_side,
  output logic            out_vld,
  output gptr_pkg::lane_t out_lanes [gptr_pkg::NL],
  output gptr_pkg::side_t out_side
);

  logic            vld  [gptr_pkg::QW+1];
  gptr_pkg::lane_t ln   [gptr_pkg::QW+1][gptr_pkg::NL];
  gptr_pkg::side_t sd   [gptr_pkg::QW+1];

  assign vld[0] = in_vld;
  assign sd[0]  = in_side;
  assign ln[0]  = in_lanes;

  for (genvar i = 0; i < gptr_pkg::QW; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
      for (int l = 0; l < gptr_pkg::NL; l++) begin
        ln[i+1][l] <= gptr_pkg::root_step(ln[i][l], gptr_pkg::QW - 1 - i);
      end
    end
  end

  assign out_vld   = vld[gptr_pkg::QW];
  assign out_side  = sd[gptr_pkg::QW];
  assign out_lanes = ln[gptr_pkg::QW];

endmodule

[sv/gaze_to_pan_tilt_rotation.sv]
// ----------------------------------------------------------------------------
// gaze_to_pan_tilt_rotation
// Gaze vector to Rz(pan)*Ry(-tilt) rotation, nine Q1.14 entries.
//
//   port    dir  width  meaning
//   start   in   1      input beat strobe
//   busy    out  1      always low
//   gaze    in   48     gaze_x, gaze_y, gaze_z
//   done    out  1      result beat strobe, one cycle
//   result  out  144    m00..m22
//
// One vector per cycle; the result passes through 5 prep stages,
// 15 root search stages (one result bit each) and one output stage.
// rst clears the valid pipeline only. busy never rises.
// ----------------------------------------------------------------------------
module gaze_to_pan_tilt_rotation (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gptr_pkg::gaze_t gaze,
  output logic            done,
  output gptr_pkg::rot_t  result
);

  logic            p_vld, s_vld;
  gptr_pkg::lane_t p_lanes [gptr_pkg::NL];
  gptr_pkg::lane_t s_lanes [gptr_pkg::NL];
  gptr_pkg::side_t p_side, s_side;
  logic signed [15:0] m [gptr_pkg::NL];
  gptr_pkg::rot_t  result_next;

  assign busy = 1'b0;

  gptr_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .gaze  (gaze),
    .vld   (p_vld),
    .lanes (p_lanes),
    .side  (p_side)
  );

  gptr_search u_search (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (p_vld),
    .in_lanes  (p_lanes),
    .in_side   (p_side),
    .out_vld   (s_vld),
    .out_lanes (s_lanes),
    .out_side  (s_side)
  );

  always_comb begin
    for (int l = 0; l < gptr_pkg::NL; l++) begin
      m[l] = s_side.neg[l] ? -$signed(16'(s_lanes[l].q)) : $signed(16'(s_lanes[l].q));
    end
    result_next.m00 = m[gptr_pkg::L_M00];
    result_next.m01 = m[gptr_pkg::L_M01];
    result_next.m02 = m[gptr_pkg::L_M02];
    result_next.m10 = m[gptr_pkg::L_M10];
    result_next.m11 = m[gptr_pkg::L_M11];
    result_next.m12 = m[gptr_pkg::L_M12];
    result_next.m20 = m[gptr_pkg::L_M20];
    result_next.m21 = 16'sd0;
    result_next.m22 = m[gptr_pkg::L_M22];
    if (s_side.zero_all) begin
      result_next = '0;
      result_next.m00 = $signed(16'(gptr_pkg::QONE));
      result_next.m11 = $signed(16'(gptr_pkg::QONE));
      result_next.m22 = $signed(16'(gptr_pkg::QONE));
    end else if (s_side.vert) begin
      result_next = '0;
      result_next.m11 = $signed(16'(gptr_pkg::QONE));
      result_next.m20 = s_side.z_pos ? $signed(16'(gptr_pkg::QONE))
                                     : -$signed(16'(gptr_pkg::QONE));
      result_next.m02 = -result_next.m20;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
